// ===== rtl/core/vital_sign_persistence_alarm_unit_assert.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the vital sign persistence alarm unit
// Concurrent assertion wrappers; they compile to nothing under synthesis.
// ----------------------------------------------------------------------------
`ifndef VITAL_SIGN_PERSISTENCE_ALARM_UNIT_ASSERT_SVH
`define VITAL_SIGN_PERSISTENCE_ALARM_UNIT_ASSERT_SVH
`ifndef SYNTHESIS
// Same-cycle implication, disabled while reset is asserted.
`define VSPA_ASSERT_SAME(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("vspa assertion failed");
// Next-cycle implication, disabled while reset is asserted.
`define VSPA_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("vspa assertion failed");
`else
`define VSPA_ASSERT_SAME(label, clk, rst_n, ante, cons)
`define VSPA_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

// ===== rtl/core/vspa_pkg.sv =====
// ----------------------------------------------------------------------------
// vspa_pkg
// Shared types, codes and constants of the vital sign persistence alarm unit.
// ----------------------------------------------------------------------------
package vspa_pkg;

  localparam int unsigned SampleW = 12;
  localparam int unsigned ValueW  = 9;
  localparam int unsigned LimitW  = 10;
  localparam int unsigned RunW    = 16;
  localparam int unsigned CfgIdxW = 3;
  localparam int unsigned CfgDatW = 16;

  // ECG scale sample*733/10000 done as a multiply by a rounded-up reciprocal.
  // With a 28-bit shift the error stays far below one step of 1/10000, so the
  // truncated product equals the exact floor for every 12-bit sample.
  localparam int unsigned EcgRecipW = 25;
  localparam logic [EcgRecipW-1:0] EcgRecip = 25'd19676319;
  localparam int unsigned EcgShift = 28;
  localparam int unsigned EcgProdW = SampleW + EcgRecipW;

  // Temperature scale 340 + sample*60/4096.
  localparam int unsigned TempMulW  = 6;
  localparam logic [TempMulW-1:0] TempMul = 6'd60;
  localparam int unsigned TempShift = 12;
  localparam int unsigned TempProdW = SampleW + TempMulW;
  localparam logic [ValueW-1:0] TempBase = 9'd340;

  // Register reset values.
  localparam logic [LimitW-1:0] EcgHighRst  = 10'd285;
  localparam logic [LimitW-1:0] EcgLowRst   = 10'd15;
  localparam logic [LimitW-1:0] TempHighRst = 10'd375;
  localparam logic [LimitW-1:0] TempLowRst  = 10'd350;
  localparam logic [RunW-1:0]   RaiseRst    = 16'd50;
  localparam logic [RunW-1:0]   ClearRst    = 16'd20;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_ECG_HIGH  = 3'd0,
    CFG_ECG_LOW   = 3'd1,
    CFG_TEMP_HIGH = 3'd2,
    CFG_TEMP_LOW  = 3'd3,
    CFG_RAISE_RUN = 3'd4,
    CFG_CLEAR_RUN = 3'd5
  } cfg_reg_e;

  typedef enum logic [1:0] {
    EV_NONE  = 2'd0,
    EV_RAISE = 2'd1,
    EV_CLEAR = 2'd2
  } alarm_event_e;

  typedef enum logic [1:0] {
    RNG_INSIDE = 2'd0,
    RNG_UNDER  = 2'd1,
    RNG_OVER   = 2'd2
  } range_class_e;

  typedef struct packed {
    logic               channel;
    logic [SampleW-1:0] sample;
  } in_item_t;

  typedef struct packed {
    logic              out_channel;
    logic [ValueW-1:0] scaled_value;
    logic [1:0]        alarm_event;
    logic              alarm_level;
  } out_item_t;

  // Update request from the datapath to the run tracker.
  typedef struct packed {
    logic         update;
    logic         channel;
    range_class_e rng_class;
  } run_req_t;

  // Alarm decision returned by the run tracker for the current request.
  typedef struct packed {
    alarm_event_e alarm_ev;
    logic         level;
  } run_rsp_t;

  // Saturating increment of a run counter.
  function automatic logic [RunW-1:0] sat_inc(input logic [RunW-1:0] v);
    return (v == {RunW{1'b1}}) ? v : v + 1'b1;
  endfunction

endpackage

// ===== rtl/core/vspa_run_track.sv =====
// ----------------------------------------------------------------------------
// vspa_run_track
// Per-channel run counters and alarm flags with the raise and clear decision.
// ----------------------------------------------------------------------------
module vspa_run_track (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  vspa_pkg::run_req_t            req_i,
  input  logic [vspa_pkg::RunW-1:0]     raise_run_i,
  input  logic [vspa_pkg::RunW-1:0]     clear_run_i,
  output vspa_pkg::run_rsp_t            rsp_o
);

  logic [vspa_pkg::RunW-1:0] under_q  [2];
  logic [vspa_pkg::RunW-1:0] over_q   [2];
  logic [vspa_pkg::RunW-1:0] inside_q [2];
  logic [1:0]                flag_q;

  logic [vspa_pkg::RunW-1:0] under_d;
  logic [vspa_pkg::RunW-1:0] over_d;
  logic [vspa_pkg::RunW-1:0] inside_d;
  logic                      flag_d;
  logic                      raise;
  logic                      clear;

  always_comb begin
    under_d  = '0;
    over_d   = '0;
    inside_d = '0;
    case (req_i.rng_class)
      vspa_pkg::RNG_UNDER: under_d  = vspa_pkg::sat_inc(under_q[req_i.channel]);
      vspa_pkg::RNG_OVER:  over_d   = vspa_pkg::sat_inc(over_q[req_i.channel]);
      default:             inside_d = vspa_pkg::sat_inc(inside_q[req_i.channel]);
    endcase

    clear = (req_i.rng_class == vspa_pkg::RNG_INSIDE) && (inside_d > clear_run_i);
    raise = (over_d > raise_run_i) || (under_d > raise_run_i);

    // A raise always wins; it cannot coincide with a clear anyway.
    if (raise) begin
      flag_d         = 1'b1;
      rsp_o.alarm_ev = vspa_pkg::EV_RAISE;
    end else if (clear) begin
      flag_d         = 1'b0;
      rsp_o.alarm_ev = vspa_pkg::EV_CLEAR;
    end else begin
      flag_d         = flag_q[req_i.channel];
      rsp_o.alarm_ev = vspa_pkg::EV_NONE;
    end
    rsp_o.level = flag_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      under_q  <= '{default: '0};
      over_q   <= '{default: '0};
      inside_q <= '{default: '0};
      flag_q   <= '0;
    end else if (req_i.update) begin
      under_q[req_i.channel]  <= under_d;
      over_q[req_i.channel]   <= over_d;
      inside_q[req_i.channel] <= inside_d;
      flag_q[req_i.channel]   <= flag_d;
    end
  end

endmodule

// ===== rtl/core/vital_sign_persistence_alarm_unit.sv =====
// ----------------------------------------------------------------------------
// vital_sign_persistence_alarm_unit
// Window comparator with a persistence filter for an ECG and a temperature
// channel, raising and clearing a per-channel alarm.
// ----------------------------------------------------------------------------
// Usage: a tagged 12-bit converter word enters on the input channel
// (in_valid_i, in_stall_o, in_item_i). Channel 0 is ECG, channel 1 is
// temperature. Each input word yields exactly one result word on the output
// channel (out_valid_o, out_stall_i, out_item_o) carrying the channel, the
// scaled reading, the alarm event of this sample and the channel's alarm level.
// An accepted word sits in the input register while scaling, window compare
// and run update settle, and the result lands in the result register once
// that register is free. Throughput is one word per cycle while the receiver
// does not stall, and a new word is accepted while an earlier result still
// waits to be taken.
// When the receiver stalls, the result register holds and the input register
// fills; in_stall_o rises only when both are occupied. Thresholds are written
// through the configuration channel (always ready); the user writes them only
// while the unit is idle, which the unit does not enforce. Reset clears all run
// counters and alarm flags and loads the default limits and run thresholds.
// ----------------------------------------------------------------------------
`include "vital_sign_persistence_alarm_unit_assert.svh"

module vital_sign_persistence_alarm_unit (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  // Input channel
  input  logic                             in_valid_i,
  output logic                             in_stall_o,
  input  vspa_pkg::in_item_t               in_item_i,
  // Output channel
  output logic                             out_valid_o,
  input  logic                             out_stall_i,
  output vspa_pkg::out_item_t              out_item_o,
  // Configuration write channel
  input  logic                             cfg_valid_i,
  output logic                             cfg_ready_o,
  input  logic [vspa_pkg::CfgIdxW-1:0]     cfg_index_i,
  input  logic [vspa_pkg::CfgDatW-1:0]     cfg_data_i
);

  // Configuration registers.
  logic [vspa_pkg::LimitW-1:0] ecg_high_q;
  logic [vspa_pkg::LimitW-1:0] ecg_low_q;
  logic [vspa_pkg::LimitW-1:0] temp_high_q;
  logic [vspa_pkg::LimitW-1:0] temp_low_q;
  logic [vspa_pkg::RunW-1:0]   raise_run_q;
  logic [vspa_pkg::RunW-1:0]   clear_run_q;

  // Input register and result register.
  logic                 s1_valid_q, s1_valid_d;
  vspa_pkg::in_item_t   s1_item_q;
  logic                 out_valid_q, out_valid_d;
  vspa_pkg::out_item_t  out_item_q, out_item_d;

  logic in_accept;
  logic out_free;
  logic advance;

  // Datapath signals.
  logic [vspa_pkg::EcgProdW-1:0]  ecg_prod;
  logic [vspa_pkg::TempProdW-1:0] temp_prod;
  logic [vspa_pkg::ValueW-1:0]    ecg_value;
  logic [vspa_pkg::ValueW-1:0]    temp_value;
  logic [vspa_pkg::ValueW-1:0]    value;
  logic [vspa_pkg::LimitW-1:0]    value_ext;
  logic [vspa_pkg::LimitW-1:0]    low_lim;
  logic [vspa_pkg::LimitW-1:0]    high_lim;

  vspa_pkg::run_req_t run_req;
  vspa_pkg::run_rsp_t run_rsp;

  // The configuration port never back-pressures.
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ecg_high_q  <= vspa_pkg::EcgHighRst;
      ecg_low_q   <= vspa_pkg::EcgLowRst;
      temp_high_q <= vspa_pkg::TempHighRst;
      temp_low_q  <= vspa_pkg::TempLowRst;
      raise_run_q <= vspa_pkg::RaiseRst;
      clear_run_q <= vspa_pkg::ClearRst;
    end else if (cfg_valid_i) begin
      // Upper data bits beyond a limit's width are dropped; unknown indexes
      // write nothing.
      unique case (vspa_pkg::cfg_reg_e'(cfg_index_i))
        vspa_pkg::CFG_ECG_HIGH:  ecg_high_q  <= cfg_data_i[vspa_pkg::LimitW-1:0];
        vspa_pkg::CFG_ECG_LOW:   ecg_low_q   <= cfg_data_i[vspa_pkg::LimitW-1:0];
        vspa_pkg::CFG_TEMP_HIGH: temp_high_q <= cfg_data_i[vspa_pkg::LimitW-1:0];
        vspa_pkg::CFG_TEMP_LOW:  temp_low_q  <= cfg_data_i[vspa_pkg::LimitW-1:0];
        vspa_pkg::CFG_RAISE_RUN: raise_run_q <= cfg_data_i[vspa_pkg::RunW-1:0];
        vspa_pkg::CFG_CLEAR_RUN: clear_run_q <= cfg_data_i[vspa_pkg::RunW-1:0];
        default: ;
      endcase
    end
  end

  // Handshake. The result register is free when empty or being taken this
  // cycle; the input register moves forward whenever the result register is
  // free, so the input side stalls only when both stages hold a word.
  assign out_free   = !out_valid_q || !out_stall_i;
  assign advance    = s1_valid_q && out_free;
  assign in_stall_o = s1_valid_q && !out_free;
  assign in_accept  = in_valid_i && !in_stall_o;

  always_comb begin
    s1_valid_d = s1_valid_q;
    if (in_accept) begin
      s1_valid_d = 1'b1;
    end else if (advance) begin
      s1_valid_d = 1'b0;
    end

    out_valid_d = out_valid_q;
    if (advance) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  // Scaling. ECG uses a reciprocal multiply that is exact for all 12-bit
  // samples; temperature is a multiply by 60, a shift by 12 and an offset of 340.
  assign ecg_prod  = vspa_pkg::EcgProdW'(s1_item_q.sample) *
                     vspa_pkg::EcgProdW'(vspa_pkg::EcgRecip);
  assign ecg_value = ecg_prod[vspa_pkg::EcgShift +: vspa_pkg::ValueW];

  assign temp_prod  = vspa_pkg::TempProdW'(s1_item_q.sample) *
                      vspa_pkg::TempProdW'(vspa_pkg::TempMul);
  assign temp_value = vspa_pkg::TempBase +
                      vspa_pkg::ValueW'(temp_prod[vspa_pkg::TempProdW-1:vspa_pkg::TempShift]);

  // Window compare against the limits of the sample's channel. The low test
  // is taken first, so a crossed window reads as under range.
  always_comb begin
    if (s1_item_q.channel) begin
      value    = temp_value;
      low_lim  = temp_low_q;
      high_lim = temp_high_q;
    end else begin
      value    = ecg_value;
      low_lim  = ecg_low_q;
      high_lim = ecg_high_q;
    end
    value_ext = vspa_pkg::LimitW'(value);

    run_req.update  = advance;
    run_req.channel = s1_item_q.channel;
    if (value_ext < low_lim) begin
      run_req.rng_class = vspa_pkg::RNG_UNDER;
    end else if (value_ext > high_lim) begin
      run_req.rng_class = vspa_pkg::RNG_OVER;
    end else begin
      run_req.rng_class = vspa_pkg::RNG_INSIDE;
    end
  end

  vspa_run_track u_run_track (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_i       (run_req),
    .raise_run_i (raise_run_q),
    .clear_run_i (clear_run_q),
    .rsp_o       (run_rsp)
  );

  always_comb begin
    out_item_d.out_channel  = s1_item_q.channel;
    out_item_d.scaled_value = value;
    out_item_d.alarm_event  = run_rsp.alarm_ev;
    out_item_d.alarm_level  = run_rsp.level;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      s1_valid_q  <= s1_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload registers carry no reset.
  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      s1_item_q <= in_item_i;
    end
    if (advance) begin
      out_item_q <= out_item_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_item_q;

  // A word leaving the input register shows up as a result next cycle.
  `VSPA_ASSERT_NEXT(a_advance_to_out, clk_i, rst_ni, advance, out_valid_o)
  // An accepted input word occupies the input register next cycle.
  `VSPA_ASSERT_NEXT(a_accept_fills_s1, clk_i, rst_ni, in_accept, s1_valid_q)
  // A raise event always reports the alarm as active.
  `VSPA_ASSERT_SAME(a_raise_level, clk_i, rst_ni,
    out_valid_o && (out_item_o.alarm_event == vspa_pkg::EV_RAISE),
    out_item_o.alarm_level)
  // A clear event always reports the alarm as inactive.
  `VSPA_ASSERT_SAME(a_clear_level, clk_i, rst_ni,
    out_valid_o && (out_item_o.alarm_event == vspa_pkg::EV_CLEAR),
    !out_item_o.alarm_level)

endmodule
